/* rtl/stage2_page_table_builder_defines.svh */
// Assertion macros shared by the page table builder RTL.
`ifndef STAGE2_PAGE_TABLE_BUILDER_DEFINES_SVH
`define STAGE2_PAGE_TABLE_BUILDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define S2PTB_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("stage2_page_table_builder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define S2PTB_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("stage2_page_table_builder: next-cycle check failed");

`endif

/* rtl/s2ptb_pkg.sv */
// Types, constants and helpers shared by the page table builder modules.
`default_nettype none
package s2ptb_pkg;

    localparam int ROOT_ENTRIES  = 2048;
    localparam int TABLE_ENTRIES = 512;
    localparam int PPN_W         = 44;

    localparam logic [9:0]  LEAF_BITS  = 10'h0DF;
    localparam logic [21:0] STEP_NONE  = 22'h000000;
    localparam logic [21:0] STEP_PAGE  = 22'h001000;
    localparam logic [21:0] STEP_MEGA  = 22'h200000;
    localparam logic [3:0]  HGATP_MODE = 4'h8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_L1_FULL = 2'd1;
    localparam logic [1:0] ST_L0_FULL = 2'd2;

    localparam logic MODE_READ = 1'b1;

    localparam logic [1:0] LVL_ROOT = 2'd0;
    localparam logic [1:0] LVL_L1   = 2'd1;
    localparam logic [1:0] LVL_L0   = 2'd2;

    localparam logic [1:0] CFG_ROOT_PPN = 2'd0;
    localparam logic [1:0] CFG_L1_POOL  = 2'd1;
    localparam logic [1:0] CFG_L0_POOL  = 2'd2;
    localparam logic [1:0] CFG_VMID     = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDW,
        S_ROOT,
        S_L1,
        S_SPLIT,
        S_LEAF,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        is_read;
        logic        rem_zero;
        logic        mega;
        logic [40:0] addr;
        logic [1:0]  level;
        logic [2:0]  tbl;
        logic [10:0] ent;
    } t_cmd;

    typedef struct packed {
        logic [PPN_W-1:0] l1_pool;
        logic [PPN_W-1:0] l0_pool;
    } t_cfg;

    typedef struct packed {
        logic [21:0] step;
        logic [1:0]  status;
        logic [63:0] data;
    } t_res;

    // Pointer entry to the table at base + idx.
    function automatic logic [63:0] f_link(input logic [PPN_W-1:0] base,
                                           input logic [PPN_W-1:0] idx);
        logic [PPN_W-1:0] sum;
        sum = base + idx;
        return {10'b0, sum, 9'b0, 1'b1};
    endfunction

endpackage
`default_nettype wire

/* rtl/s2ptb_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none
module s2ptb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* rtl/s2ptb_front.sv */
// Front end: accepts input beats, classifies them and queues commands.
`default_nettype none
module s2ptb_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_mode,
    input  wire logic [40:0]      i_guest_addr,
    input  wire logic [41:0]      i_remaining_bytes,
    input  wire logic             i_page_only,
    input  wire logic [1:0]       i_read_level,
    input  wire logic [2:0]       i_read_table,
    input  wire logic [10:0]      i_read_entry,
    input  wire logic             i_clearing,
    output logic                  o_cmd_valid,
    output s2ptb_pkg::t_cmd       o_cmd,
    input  wire logic             i_cmd_pop
);
    s2ptb_pkg::t_cmd r_q [2];
    s2ptb_pkg::t_cmd cmd;
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push;

    always_comb begin
        cmd.is_read  = (i_mode == s2ptb_pkg::MODE_READ);
        cmd.rem_zero = (i_remaining_bytes == '0);
        // Megapage only on a 2MB boundary with at least 2MB left.
        cmd.mega     = (i_guest_addr[20:0] == '0) && (i_remaining_bytes[41:21] != '0)
                       && !i_page_only;
        cmd.addr     = i_guest_addr;
        cmd.level    = i_read_level;
        cmd.tbl      = i_read_table;
        cmd.ent      = i_read_entry;
    end

    assign o_stall     = (r_cnt == 2'd2) || i_clearing;
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/s2ptb_back.sv */
// Back end: table memories and the sequencer that carries out commands.
`default_nettype none
module s2ptb_back #(
    parameter int L1_TABLES = 4,
    parameter int L0_TABLES = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  s2ptb_pkg::t_cfg      i_cfg,
    input  wire logic            i_cmd_valid,
    input  s2ptb_pkg::t_cmd      i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_clearing,
    output logic                 o_res_valid,
    output s2ptb_pkg::t_res      o_res,
    input  wire logic            i_res_take
);
    localparam int L1W      = (L1_TABLES > 1) ? $clog2(L1_TABLES) : 1;
    localparam int L0W      = (L0_TABLES > 1) ? $clog2(L0_TABLES) : 1;
    localparam int U1W      = $clog2(L1_TABLES + 1);
    localparam int U0W      = $clog2(L0_TABLES + 1);
    localparam int EW       = $clog2(s2ptb_pkg::TABLE_ENTRIES);
    localparam int ROOT_AW  = $clog2(s2ptb_pkg::ROOT_ENTRIES);
    localparam int L1_DEPTH = L1_TABLES * s2ptb_pkg::TABLE_ENTRIES;
    localparam int L0_DEPTH = L0_TABLES * s2ptb_pkg::TABLE_ENTRIES;
    localparam int L1_AW    = $clog2(L1_DEPTH);
    localparam int L0_AW    = $clog2(L0_DEPTH);
    localparam int CLR_A    = (L1_DEPTH > s2ptb_pkg::ROOT_ENTRIES) ?
                              L1_DEPTH : s2ptb_pkg::ROOT_ENTRIES;
    localparam int CLR_N    = (L0_DEPTH > CLR_A) ? L0_DEPTH : CLR_A;
    localparam int CLR_W    = $clog2(CLR_N);

    s2ptb_pkg::t_state r_state, n_state;
    s2ptb_pkg::t_cmd   r_cmd, n_cmd;
    s2ptb_pkg::t_res   r_res, n_res;
    logic              r_new_l1, n_new_l1;
    logic [L1W-1:0]    r_t1, n_t1;
    logic [L0W-1:0]    r_t0, n_t0;
    logic [53:0]       r_ppn, n_ppn;
    logic [EW-1:0]     r_j, n_j;
    logic [CLR_W-1:0]  r_cnt, n_cnt;
    logic [U1W-1:0]    r_l1_used, n_l1_used;
    logic [U0W-1:0]    r_l0_used, n_l0_used;
    logic              r_rd_ok, n_rd_ok;

    logic               root_we, l1_we, l0_we;
    logic [ROOT_AW-1:0] root_addr;
    logic [L1_AW-1:0]   l1_addr;
    logic [L0_AW-1:0]   l0_addr;
    logic [63:0]        root_wd, l1_wd, l0_wd, root_q, l1_q, l0_q;

    logic [43:0] d1, d0;
    logic [63:0] e_c, leaf;
    logic        split_c, need0_c;
    logic [8:0]  vpn1, vpn0;
    logic [10:0] vpn2;

    assign vpn2    = r_cmd.addr[40:30];
    assign vpn1    = r_cmd.addr[29:21];
    assign vpn0    = r_cmd.addr[20:12];
    assign d1      = root_q[53:10] - i_cfg.l1_pool;
    assign e_c     = r_new_l1 ? 64'd0 : l1_q;
    assign d0      = e_c[53:10] - i_cfg.l0_pool;
    assign split_c = (e_c[3:1] != 3'd0);
    assign need0_c = split_c || !e_c[0];
    assign leaf    = {25'b0, r_cmd.addr[40:12], s2ptb_pkg::LEAF_BITS};

    assign o_clearing  = (r_state == s2ptb_pkg::S_CLEAR);
    assign o_res_valid = (r_state == s2ptb_pkg::S_DONE);
    assign o_res       = r_res;

    always_comb begin
        logic           fail;
        logic [L1W-1:0] t1;
        logic [L0W-1:0] t0;
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_new_l1  = r_new_l1;
        n_t1      = r_t1;
        n_t0      = r_t0;
        n_ppn     = r_ppn;
        n_j       = r_j;
        n_cnt     = r_cnt;
        n_l1_used = r_l1_used;
        n_l0_used = r_l0_used;
        n_rd_ok   = r_rd_ok;
        o_cmd_pop = 1'b0;
        root_we   = 1'b0;
        l1_we     = 1'b0;
        l0_we     = 1'b0;
        root_addr = vpn2;
        l1_addr   = L1_AW'({r_t1, vpn1});
        l0_addr   = L0_AW'({r_t0, vpn0});
        root_wd   = s2ptb_pkg::f_link(i_cfg.l1_pool, 44'(r_t1));
        l1_wd     = leaf;
        l0_wd     = leaf;
        fail      = 1'b0;
        t1        = r_t1;
        t0        = r_t0;
        unique case (r_state)
            s2ptb_pkg::S_CLEAR: begin
                root_we   = (32'(r_cnt) < s2ptb_pkg::ROOT_ENTRIES);
                l1_we     = (32'(r_cnt) < L1_DEPTH);
                l0_we     = (32'(r_cnt) < L0_DEPTH);
                root_addr = r_cnt[ROOT_AW-1:0];
                l1_addr   = r_cnt[L1_AW-1:0];
                l0_addr   = r_cnt[L0_AW-1:0];
                root_wd   = '0;
                l1_wd     = '0;
                l0_wd     = '0;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CLR_W'(CLR_N - 1)) begin
                    n_state = s2ptb_pkg::S_IDLE;
                end
            end
            s2ptb_pkg::S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                root_addr = i_cmd.is_read ? i_cmd.ent : i_cmd.addr[40:30];
                l1_addr   = L1_AW'({L1W'(i_cmd.tbl), i_cmd.ent[8:0]});
                l0_addr   = L0_AW'({L0W'(i_cmd.tbl), i_cmd.ent[8:0]});
                unique case (i_cmd.level)
                    s2ptb_pkg::LVL_ROOT: n_rd_ok = 1'b1;
                    s2ptb_pkg::LVL_L1:   n_rd_ok = (i_cmd.ent[10:9] == 2'd0)
                                                   && (32'(i_cmd.tbl) < L1_TABLES);
                    s2ptb_pkg::LVL_L0:   n_rd_ok = (i_cmd.ent[10:9] == 2'd0)
                                                   && (32'(i_cmd.tbl) < L0_TABLES);
                    default:             n_rd_ok = 1'b0;
                endcase
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    if (i_cmd.is_read) begin
                        n_state = s2ptb_pkg::S_RDW;
                    end else if (i_cmd.rem_zero) begin
                        n_res   = '0;
                        n_state = s2ptb_pkg::S_DONE;
                    end else begin
                        n_state = s2ptb_pkg::S_ROOT;
                    end
                end
            end
            s2ptb_pkg::S_RDW: begin
                n_res.step   = s2ptb_pkg::STEP_NONE;
                n_res.status = s2ptb_pkg::ST_OK;
                n_res.data   = '0;
                if (r_rd_ok) begin
                    unique case (r_cmd.level)
                        s2ptb_pkg::LVL_ROOT: n_res.data = root_q;
                        s2ptb_pkg::LVL_L1:   n_res.data = l1_q;
                        default:             n_res.data = l0_q;
                    endcase
                end
                n_state = s2ptb_pkg::S_DONE;
            end
            s2ptb_pkg::S_ROOT: begin
                n_new_l1 = !root_q[0];
                if (!root_q[0]) begin
                    fail = (32'(r_l1_used) >= L1_TABLES);
                    t1   = r_l1_used[L1W-1:0];
                end else begin
                    fail = (d1 >= 44'(r_l1_used));
                    t1   = d1[L1W-1:0];
                end
                n_t1    = t1;
                l1_addr = L1_AW'({t1, vpn1});
                if (fail) begin
                    n_res   = '{step: s2ptb_pkg::STEP_NONE, status: s2ptb_pkg::ST_L1_FULL,
                                data: 64'd0};
                    n_state = s2ptb_pkg::S_DONE;
                end else begin
                    n_state = s2ptb_pkg::S_L1;
                end
            end
            s2ptb_pkg::S_L1: begin
                n_res.data   = '0;
                n_res.status = s2ptb_pkg::ST_OK;
                n_res.step   = s2ptb_pkg::STEP_PAGE;
                n_state      = s2ptb_pkg::S_DONE;
                if (r_cmd.mega) begin
                    root_we    = r_new_l1;
                    n_l1_used  = r_l1_used + U1W'(r_new_l1);
                    l1_we      = 1'b1;
                    n_res.step = s2ptb_pkg::STEP_MEGA;
                end else begin
                    if (need0_c) begin
                        fail = (32'(r_l0_used) >= L0_TABLES);
                        t0   = r_l0_used[L0W-1:0];
                    end else begin
                        fail = (d0 >= 44'(r_l0_used));
                        t0   = d0[L0W-1:0];
                    end
                    n_t0    = t0;
                    l0_addr = L0_AW'({t0, vpn0});
                    l1_wd   = s2ptb_pkg::f_link(i_cfg.l0_pool, 44'(t0));
                    if (fail) begin
                        n_res.step   = s2ptb_pkg::STEP_NONE;
                        n_res.status = s2ptb_pkg::ST_L0_FULL;
                    end else begin
                        root_we   = r_new_l1;
                        n_l1_used = r_l1_used + U1W'(r_new_l1);
                        l1_we     = need0_c;
                        n_l0_used = r_l0_used + U0W'(need0_c);
                        if (split_c) begin
                            // Expand the megapage into 512 leaves before the new page.
                            n_ppn   = e_c[63:10];
                            n_j     = '0;
                            n_state = s2ptb_pkg::S_SPLIT;
                        end else begin
                            l0_we = 1'b1;
                        end
                    end
                end
            end
            s2ptb_pkg::S_SPLIT: begin
                l0_we   = 1'b1;
                l0_addr = L0_AW'({r_t0, r_j});
                l0_wd   = {r_ppn + 54'(r_j), s2ptb_pkg::LEAF_BITS};
                n_j     = r_j + 1'b1;
                if (r_j == '1) begin
                    n_state = s2ptb_pkg::S_LEAF;
                end
            end
            s2ptb_pkg::S_LEAF: begin
                l0_we   = 1'b1;
                n_res   = '{step: s2ptb_pkg::STEP_PAGE, status: s2ptb_pkg::ST_OK,
                            data: 64'd0};
                n_state = s2ptb_pkg::S_DONE;
            end
            s2ptb_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = s2ptb_pkg::S_IDLE;
                end
            end
            default: n_state = s2ptb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= s2ptb_pkg::S_CLEAR;
            r_cnt     <= '0;
            r_l1_used <= '0;
            r_l0_used <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_l1_used <= n_l1_used;
            r_l0_used <= n_l0_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_res    <= n_res;
        r_new_l1 <= n_new_l1;
        r_t1     <= n_t1;
        r_t0     <= n_t0;
        r_ppn    <= n_ppn;
        r_j      <= n_j;
        r_rd_ok  <= n_rd_ok;
    end

    s2ptb_ram #(.WIDTH(64), .DEPTH(s2ptb_pkg::ROOT_ENTRIES)) u_root_ram (
        .i_clk(i_clk), .i_we(root_we), .i_addr(root_addr), .i_wdata(root_wd),
        .o_rdata(root_q)
    );
    s2ptb_ram #(.WIDTH(64), .DEPTH(L1_DEPTH)) u_l1_ram (
        .i_clk(i_clk), .i_we(l1_we), .i_addr(l1_addr), .i_wdata(l1_wd),
        .o_rdata(l1_q)
    );
    s2ptb_ram #(.WIDTH(64), .DEPTH(L0_DEPTH)) u_l0_ram (
        .i_clk(i_clk), .i_we(l0_we), .i_addr(l0_addr), .i_wdata(l0_wd),
        .o_rdata(l0_q)
    );
endmodule
`default_nettype wire

/* rtl/stage2_page_table_builder.sv */
// Top level of the Sv39x4 G-stage identity page table builder.
// The block builds a three-level identity-mapped G-stage table in three
// on-chip memories (root, L1 pool, L0 pool), one mapping step per input beat,
// and answers read beats with any stored entry; every result beat also
// carries the hgatp word built from the VMID and root PPN registers. After
// reset the block sweeps all three memories to zero, one entry per cycle,
// and holds o_stall high during that sweep; configuration writes are taken
// at any time. A front end queues up to two classified beats, a back end
// sequencer works them one at a time through the single-port memories:
// a read beat passes command pickup, entry read and result, a map step
// passes command pickup, root entry read, L1 entry read with the decision
// and writes, and result, and a step that splits a megapage into a fresh
// L0 table also writes the 512 leaves through the L0 memory port and then
// the new page. The result sits in an output register, so the back end goes
// on with the next beat while a result is still stalled. An exhausted or
// stale pool is reported in o_status with a zero step and leaves the tables
// untouched.
`default_nettype none
`include "stage2_page_table_builder_defines.svh"
module stage2_page_table_builder #(
    parameter int L1_TABLES = 4,
    parameter int L0_TABLES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [40:0] i_guest_addr,
    input  wire logic [41:0] i_remaining_bytes,
    input  wire logic        i_page_only,
    input  wire logic [1:0]  i_read_level,
    input  wire logic [2:0]  i_read_table,
    input  wire logic [10:0] i_read_entry,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [21:0]      o_step_bytes,
    output logic [1:0]       o_status,
    output logic [63:0]      o_read_data,
    output logic [63:0]      o_hgatp_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [43:0] i_cfg_data
);
    // Configuration registers.
    logic [43:0] r_root_ppn;
    logic [13:0] r_vmid;
    s2ptb_pkg::t_cfg r_cfg;

    // Interface between front and back.
    logic            cmd_valid, cmd_pop, clearing;
    s2ptb_pkg::t_cmd cmd;
    logic            res_valid, res_take;
    s2ptb_pkg::t_res res;

    // Output register.
    logic            r_out_valid;
    s2ptb_pkg::t_res r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_ppn <= '0;
            r_vmid     <= '0;
            r_cfg      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                s2ptb_pkg::CFG_ROOT_PPN: r_root_ppn    <= i_cfg_data;
                s2ptb_pkg::CFG_L1_POOL:  r_cfg.l1_pool <= i_cfg_data;
                s2ptb_pkg::CFG_L0_POOL:  r_cfg.l0_pool <= i_cfg_data;
                s2ptb_pkg::CFG_VMID:     r_vmid        <= i_cfg_data[13:0];
                default:                 r_vmid        <= r_vmid;
            endcase
        end
    end

    s2ptb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_guest_addr     (i_guest_addr),
        .i_remaining_bytes(i_remaining_bytes),
        .i_page_only      (i_page_only),
        .i_read_level     (i_read_level),
        .i_read_table     (i_read_table),
        .i_read_entry     (i_read_entry),
        .i_clearing       (clearing),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd),
        .i_cmd_pop        (cmd_pop)
    );

    s2ptb_back #(.L1_TABLES(L1_TABLES), .L0_TABLES(L0_TABLES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_clearing (clearing),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_take (res_take)
    );

    // The output register takes a new result whenever it is empty or drains.
    assign res_take = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_step_bytes  = r_out.step;
    assign o_status      = r_out.status;
    assign o_read_data   = r_out.data;
    // User must change config only while idle (not enforced) so the word is stable for a pending beat.
    assign o_hgatp_value = {s2ptb_pkg::HGATP_MODE, 2'b00, r_vmid, r_root_ppn};

    // No beat enters while the memories are being cleared.
    `S2PTB_ASSERT_NOW(a_no_accept_in_clear, clearing, !(i_valid && !o_stall))
    // A failed step never reports mapped bytes.
    `S2PTB_ASSERT_NOW(a_fail_no_step, o_valid && (o_status != s2ptb_pkg::ST_OK),
                      o_step_bytes == s2ptb_pkg::STEP_NONE)
    // A result handed to the output register shows up there next cycle.
    `S2PTB_ASSERT_NEXT(a_result_lands, res_valid && res_take, r_out_valid)
endmodule
`default_nettype wire
